/* rtl/core/base_bound_mmu_first_fit_alloc_macros.svh */
// Assertion macros for the base-and-bounds MMU checker.
// The including module must provide clk and rst_n.
`ifndef BASE_BOUND_MMU_FIRST_FIT_ALLOC_MACROS_SVH
`define BASE_BOUND_MMU_FIRST_FIT_ALLOC_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BBM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("base_bound_mmu_first_fit_alloc: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BBM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("base_bound_mmu_first_fit_alloc: assertion failed");

`endif

/* rtl/core/bbm_pkg.sv */
// Shared field widths, action and status codes and the sequencer state type
// for the base-and-bounds MMU. No dependencies.
`timescale 1ns / 1ps

package bbm_pkg;

    localparam int ACTION_W  = 2;
    localparam int SIZE_W    = 13;
    localparam int PID_W     = 4;
    localparam int VADDR_W   = 12;
    localparam int STATUS_W  = 3;
    localparam int PADDR_W   = 12;
    localparam int BASE_W    = 12;
    localparam int WORD_BITS = 32;
    localparam int LANE_W    = 5;

    localparam logic [ACTION_W-1:0] ACT_CREATE    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SWITCH    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TRANSLATE = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_RUN  = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_NO_SLOT = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FAULT   = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_BAD_PID = 3'd4;

    typedef logic [WORD_BITS-1:0] word_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_MARK,
        ST_SLOT,
        ST_DONE
    } state_t;

endpackage

/* rtl/core/bbm_cmd_if.sv */
// Command channel of the base-and-bounds MMU: valid/ready plus the action fields.
// Depends on bbm_pkg.
`timescale 1ns / 1ps

interface bbm_cmd_if
    import bbm_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [SIZE_W-1:0]   size;
    logic [PID_W-1:0]    pid;
    logic [VADDR_W-1:0]  virt_addr;

    modport source (output valid, action, size, pid, virt_addr, input ready);
    modport sink   (input valid, action, size, pid, virt_addr, output ready);
endinterface

/* rtl/core/bbm_rsp_if.sv */
// Response channel of the base-and-bounds MMU: valid/ready plus the result fields.
// Depends on bbm_pkg.
`timescale 1ns / 1ps

interface bbm_rsp_if
    import bbm_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [PID_W-1:0]    new_pid;
    logic [PADDR_W-1:0]  physical_address;
    logic                previous_valid;
    logic [PID_W-1:0]    previous_pid;

    modport source (output valid, status, new_pid, physical_address, previous_valid,
                    previous_pid, input ready);
    modport sink   (input valid, status, new_pid, physical_address, previous_valid,
                    previous_pid, output ready);
endinterface

/* rtl/core/bbm_run_finder.sv */
// Free-run finder: evaluates one word of the allocation map against the run
// carried in from lower words. Depends on bbm_pkg.
`timescale 1ns / 1ps

module bbm_run_finder
    import bbm_pkg::*;
#(
    parameter int RW = 13
)(
    input  word_t             map_word,
    input  word_t             lane_ok,
    input  logic [RW-1:0]     carry_in,
    input  logic [RW-1:0]     len,
    output logic              found,
    output logic [LANE_W-1:0] hit_lane,
    output logic [RW-1:0]     carry_out
);

    // Each prefix-network level copies the nearest used position from further
    // down, so after the last level each lane knows its nearest used bit, if any.
    word_t             has_used [LANE_W+1];
    logic [LANE_W-1:0] used_pos [LANE_W+1][WORD_BITS];
    logic [RW-1:0]     run_len  [WORD_BITS];
    word_t             hit;

    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
        begin
            has_used[0][i] = map_word[i] | ~lane_ok[i];
            used_pos[0][i] = LANE_W'(i);
        end
        for (int lv = 0; lv < LANE_W; lv++)
        begin
            for (int i = 0; i < WORD_BITS; i++)
            begin
                if ((i >= (1 << lv)) && !has_used[lv][i])
                begin
                    has_used[lv+1][i] = has_used[lv][i - (1 << lv)];
                    used_pos[lv+1][i] = used_pos[lv][i - (1 << lv)];
                end
                else
                begin
                    has_used[lv+1][i] = has_used[lv][i];
                    used_pos[lv+1][i] = used_pos[lv][i];
                end
            end
        end
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (has_used[LANE_W][i])
            begin
                run_len[i] = RW'(i) - RW'(used_pos[LANE_W][i]);
            end
            else
            begin
                run_len[i] = carry_in + RW'(i + 1);
            end
            hit[i] = (run_len[i] >= len);
        end
    end

    always_comb
    begin
        hit_lane = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                hit_lane = LANE_W'(i);
            end
        end
    end

    assign found     = |hit;
    assign carry_out = run_len[WORD_BITS-1];

endmodule

/* rtl/core/base_bound_mmu_first_fit_alloc.sv */
// Base-and-bounds MMU with a first-fit allocator and a small process table.
// Depends on bbm_pkg, bbm_cmd_if, bbm_rsp_if and bbm_run_finder.
//
// Usage:
// cmd carries one action per transaction: create (size), switch (pid) or
// translate (virt_addr). rsp returns exactly one transaction for each
// command, in order, with status, new_pid, physical_address, previous_valid
// and previous_pid; fields that do not apply to the action are zero.
// cmd.ready is high only while the sequencer is idle; one command is worked
// on at a time.
// Switch, translate, a create of size zero or larger than memory, and an
// unknown action go straight from idle to the done state.
// Create scans the allocation map one 32-unit word per cycle through a single
// run finder, pipelined behind the registered map read; once a run is found,
// the words it covers are read again and marked, and then a free process slot,
// if there is one, is assigned.
// After reset the map is cleared by a sweep over all its words, during which
// cmd.ready stays low.
// A finished response waits in an output register; the next command may be
// accepted meanwhile, but its own response waits until rsp.ready frees it.
`timescale 1ns / 1ps

module base_bound_mmu_first_fit_alloc
    import bbm_pkg::*;
#(
    parameter int MEM_UNITS     = 4096,
    parameter int PROCESS_SLOTS = 10
)(
    input  logic             clk,
    input  logic             rst_n,
    bbm_cmd_if.sink          cmd,
    bbm_rsp_if.source        rsp
);

    localparam int WORDS = (MEM_UNITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int GW    = WAW + LANE_W;
    localparam int RW    = $clog2(MEM_UNITS + 1);
    localparam int SW    = (PROCESS_SLOTS > 1) ? $clog2(PROCESS_SLOTS) : 1;
    localparam int TAIL  = MEM_UNITS - WORD_BITS * (WORDS - 1);
    localparam logic [WAW-1:0] LAST_WORD = WAW'(WORDS - 1);
    localparam word_t LAST_MASK = WORD_BITS'((64'd1 << TAIL) - 64'd1);

    word_t map_mem [WORDS];
    word_t map_q_reg;

    logic           mem_we;
    logic [WAW-1:0] mem_waddr;
    word_t          mem_wdata;
    logic           mem_re;
    logic [WAW-1:0] mem_raddr;

    state_t state_reg, state_next;

    logic [WAW-1:0] word_reg, word_next;
    logic           issued_all_reg, issued_all_next;
    logic           rvalid_reg, rvalid_next;
    logic [WAW-1:0] rword_reg, rword_next;
    logic [RW-1:0]  carry_reg, carry_next;
    logic [RW-1:0]  len_reg, len_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [GW-1:0]  start_reg, start_next;
    logic [GW-1:0]  end_reg, end_next;

    logic [PROCESS_SLOTS-1:0] slot_in_use_reg, slot_in_use_next;
    logic [BASE_W-1:0] slot_base_reg  [PROCESS_SLOTS];
    logic [BASE_W-1:0] slot_base_next [PROCESS_SLOTS];
    logic [SIZE_W-1:0] slot_bound_reg  [PROCESS_SLOTS];
    logic [SIZE_W-1:0] slot_bound_next [PROCESS_SLOTS];
    logic [BASE_W-1:0] live_base_reg, live_base_next;
    logic [SIZE_W-1:0] live_bound_reg, live_bound_next;
    logic              running_valid_reg, running_valid_next;
    logic [PID_W-1:0]  running_pid_reg, running_pid_next;

    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [PID_W-1:0]    res_new_pid_reg, res_new_pid_next;
    logic [PADDR_W-1:0]  res_phys_reg, res_phys_next;
    logic                res_prev_valid_reg, res_prev_valid_next;
    logic [PID_W-1:0]    res_prev_pid_reg, res_prev_pid_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [PID_W-1:0]    out_new_pid_reg, out_new_pid_next;
    logic [PADDR_W-1:0]  out_phys_reg, out_phys_next;
    logic                out_prev_valid_reg, out_prev_valid_next;
    logic [PID_W-1:0]    out_prev_pid_reg, out_prev_pid_next;

    logic              cmd_fire;
    logic              size_ok;
    logic              pid_ok;
    logic              out_free;
    word_t             lane_ok;
    logic              found;
    logic [LANE_W-1:0] hit_lane;
    logic [RW-1:0]     carry_out;
    logic [GW-1:0]     hit_end;
    logic [GW-1:0]     hit_start;
    logic [LANE_W-1:0] mask_lo;
    logic [LANE_W-1:0] mask_hi;
    word_t             mark_mask;
    logic              slot_any;
    logic [SW-1:0]     slot_pick;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_fire  = cmd.valid & cmd.ready;
    assign size_ok   = (cmd.size != '0) && (32'(cmd.size) <= MEM_UNITS);
    assign pid_ok    = (32'(cmd.pid) < PROCESS_SLOTS);
    assign out_free  = !out_valid_reg || rsp.ready;

    assign lane_ok = (rword_reg == LAST_WORD) ? LAST_MASK : '1;

    bbm_run_finder #(
        .RW (RW)
    ) u_finder (
        .map_word  (map_q_reg),
        .lane_ok   (lane_ok),
        .carry_in  (carry_reg),
        .len       (len_reg),
        .found     (found),
        .hit_lane  (hit_lane),
        .carry_out (carry_out)
    );

    assign hit_end   = {rword_reg, hit_lane};
    assign hit_start = hit_end + GW'(1) - GW'(len_reg);

    assign mask_lo   = (rword_reg == start_reg[GW-1:LANE_W]) ? start_reg[LANE_W-1:0] : '0;
    assign mask_hi   = (rword_reg == end_reg[GW-1:LANE_W]) ? end_reg[LANE_W-1:0] : '1;
    assign mark_mask = ({WORD_BITS{1'b1}} << mask_lo) & ({WORD_BITS{1'b1}} >> (~mask_hi));

    always_comb
    begin
        slot_any  = 1'b0;
        slot_pick = '0;
        for (int s = PROCESS_SLOTS - 1; s >= 0; s--)
        begin
            if (!slot_in_use_reg[s])
            begin
                slot_any  = 1'b1;
                slot_pick = SW'(s);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            map_q_reg <= map_mem[mem_raddr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (word_reg == LAST_WORD)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    if ((cmd.action == ACT_CREATE) && size_ok)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (rvalid_reg && found)
                begin
                    state_next = ST_MARK;
                end
                else if (rvalid_reg && (rword_reg == LAST_WORD))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_MARK:
            begin
                if (rvalid_reg && (rword_reg == end_reg[GW-1:LANE_W]))
                begin
                    state_next = ST_SLOT;
                end
            end
            ST_SLOT:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = rword_reg;
        mem_wdata = map_q_reg | mark_mask;
        mem_re    = 1'b0;
        mem_raddr = word_reg;

        word_next       = word_reg;
        issued_all_next = issued_all_reg;
        rvalid_next     = 1'b0;
        rword_next      = rword_reg;
        carry_next      = carry_reg;
        len_next        = len_reg;
        size_next       = size_reg;
        start_next      = start_reg;
        end_next        = end_reg;

        slot_in_use_next   = slot_in_use_reg;
        slot_base_next     = slot_base_reg;
        slot_bound_next    = slot_bound_reg;
        live_base_next     = live_base_reg;
        live_bound_next    = live_bound_reg;
        running_valid_next = running_valid_reg;
        running_pid_next   = running_pid_reg;

        res_status_next     = res_status_reg;
        res_new_pid_next    = res_new_pid_reg;
        res_phys_next       = res_phys_reg;
        res_prev_valid_next = res_prev_valid_reg;
        res_prev_pid_next   = res_prev_pid_reg;

        out_valid_next      = out_valid_reg & ~rsp.ready;
        out_status_next     = out_status_reg;
        out_new_pid_next    = out_new_pid_reg;
        out_phys_next       = out_phys_reg;
        out_prev_valid_next = out_prev_valid_reg;
        out_prev_pid_next   = out_prev_pid_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = word_reg;
                mem_wdata = '0;
                word_next = word_reg + WAW'(1);
            end
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    res_status_next     = STAT_OK;
                    res_new_pid_next    = '0;
                    res_phys_next       = '0;
                    res_prev_valid_next = 1'b0;
                    res_prev_pid_next   = '0;
                    size_next           = cmd.size;
                    len_next            = RW'(cmd.size);
                    word_next           = '0;
                    issued_all_next     = 1'b0;
                    carry_next          = '0;
                    case (cmd.action)
                        ACT_CREATE:
                        begin
                            if (!size_ok)
                            begin
                                res_status_next = STAT_NO_RUN;
                            end
                        end
                        ACT_SWITCH:
                        begin
                            if (!pid_ok)
                            begin
                                res_status_next = STAT_BAD_PID;
                            end
                            else
                            begin
                                if (running_valid_reg)
                                begin
                                    slot_base_next[SW'(running_pid_reg)]  = live_base_reg;
                                    slot_bound_next[SW'(running_pid_reg)] = live_bound_reg;
                                    res_prev_valid_next = 1'b1;
                                    res_prev_pid_next   = running_pid_reg;
                                end
                                if (running_valid_reg && (running_pid_reg == cmd.pid))
                                begin
                                    live_base_next  = live_base_reg;
                                    live_bound_next = live_bound_reg;
                                end
                                else
                                begin
                                    live_base_next  = slot_base_reg[SW'(cmd.pid)];
                                    live_bound_next = slot_bound_reg[SW'(cmd.pid)];
                                end
                                running_valid_next = 1'b1;
                                running_pid_next   = cmd.pid;
                            end
                        end
                        ACT_TRANSLATE:
                        begin
                            if ({1'b0, cmd.virt_addr} >= live_bound_reg)
                            begin
                                res_status_next = STAT_FAULT;
                            end
                            else
                            begin
                                res_phys_next = live_base_reg + cmd.virt_addr;
                            end
                        end
                        default:
                        begin
                            res_status_next = STAT_OK;
                        end
                    endcase
                end
            end
            ST_SCAN, ST_MARK:
            begin
                if (!issued_all_reg)
                begin
                    mem_re          = 1'b1;
                    rword_next      = word_reg;
                    rvalid_next     = 1'b1;
                    word_next       = word_reg + WAW'(1);
                    if (state_reg == ST_SCAN)
                    begin
                        issued_all_next = (word_reg == LAST_WORD);
                    end
                    else
                    begin
                        issued_all_next = (word_reg == end_reg[GW-1:LANE_W]);
                    end
                end
                if (state_reg == ST_SCAN)
                begin
                    if (rvalid_reg)
                    begin
                        carry_next = carry_out;
                        if (found)
                        begin
                            start_next      = hit_start;
                            end_next        = hit_end;
                            word_next       = hit_start[GW-1:LANE_W];
                            issued_all_next = 1'b0;
                            rvalid_next     = 1'b0;
                        end
                        else if (rword_reg == LAST_WORD)
                        begin
                            res_status_next = STAT_NO_RUN;
                        end
                    end
                end
                else if (rvalid_reg)
                begin
                    mem_we = 1'b1;
                    if (rword_reg == end_reg[GW-1:LANE_W])
                    begin
                        rvalid_next = 1'b0;
                    end
                end
            end
            ST_SLOT:
            begin
                if (slot_any)
                begin
                    slot_in_use_next[slot_pick] = 1'b1;
                    slot_base_next[slot_pick]   = BASE_W'(start_reg);
                    slot_bound_next[slot_pick]  = size_reg;
                    res_new_pid_next            = PID_W'(slot_pick);
                    res_status_next             = STAT_OK;
                end
                else
                begin
                    res_status_next = STAT_NO_SLOT;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    out_status_next     = res_status_reg;
                    out_new_pid_next    = res_new_pid_reg;
                    out_phys_next       = res_phys_reg;
                    out_prev_valid_next = res_prev_valid_reg;
                    out_prev_pid_next   = res_prev_pid_reg;
                end
            end
            default:
            begin
                rvalid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_CLEAR;
            word_reg           <= '0;
            issued_all_reg     <= 1'b0;
            rvalid_reg         <= 1'b0;
            slot_in_use_reg    <= '0;
            for (int s = 0; s < PROCESS_SLOTS; s++)
            begin
                slot_base_reg[s]  <= '0;
                slot_bound_reg[s] <= '0;
            end
            live_base_reg      <= '0;
            live_bound_reg     <= '0;
            running_valid_reg  <= 1'b0;
            running_pid_reg    <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            word_reg           <= word_next;
            issued_all_reg     <= issued_all_next;
            rvalid_reg         <= rvalid_next;
            slot_in_use_reg    <= slot_in_use_next;
            slot_base_reg      <= slot_base_next;
            slot_bound_reg     <= slot_bound_next;
            live_base_reg      <= live_base_next;
            live_bound_reg     <= live_bound_next;
            running_valid_reg  <= running_valid_next;
            running_pid_reg    <= running_pid_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rword_reg          <= rword_next;
        carry_reg          <= carry_next;
        len_reg            <= len_next;
        size_reg           <= size_next;
        start_reg          <= start_next;
        end_reg            <= end_next;
        res_status_reg     <= res_status_next;
        res_new_pid_reg    <= res_new_pid_next;
        res_phys_reg       <= res_phys_next;
        res_prev_valid_reg <= res_prev_valid_next;
        res_prev_pid_reg   <= res_prev_pid_next;
        out_status_reg     <= out_status_next;
        out_new_pid_reg    <= out_new_pid_next;
        out_phys_reg       <= out_phys_next;
        out_prev_valid_reg <= out_prev_valid_next;
        out_prev_pid_reg   <= out_prev_pid_next;
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.status           = out_status_reg;
    assign rsp.new_pid          = out_new_pid_reg;
    assign rsp.physical_address = out_phys_reg;
    assign rsp.previous_valid   = out_prev_valid_reg;
    assign rsp.previous_pid     = out_prev_pid_reg;

endmodule

/* rtl/core/bbm_checker.sv */
// Port-level checker for the base-and-bounds MMU, bound to the top level.
// Depends on bbm_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "base_bound_mmu_first_fit_alloc_macros.svh"

module bbm_checker
    import bbm_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                cmd_valid,
    input logic                cmd_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [STATUS_W-1:0] rsp_status,
    input logic [PID_W-1:0]    rsp_new_pid,
    input logic [PADDR_W-1:0]  rsp_physical_address,
    input logic                rsp_previous_valid
);

    // Accepting a command takes the sequencer out of idle, so cmd_ready drops.
    `BBM_ASSERT_NEXT(a_busy_after_accept, cmd_valid && cmd_ready, !cmd_ready)

    `BBM_ASSERT_IMP(a_fault_clean, rsp_valid && (rsp_status == STAT_FAULT), (rsp_physical_address == '0) && (rsp_new_pid == '0) && !rsp_previous_valid)

    `BBM_ASSERT_IMP(a_prev_only_switch, rsp_valid && rsp_previous_valid, (rsp_status == STAT_OK) && (rsp_new_pid == '0) && (rsp_physical_address == '0))

    `BBM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_physical_address))

endmodule

bind base_bound_mmu_first_fit_alloc bbm_checker u_bbm_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd_valid            (cmd.valid),
    .cmd_ready            (cmd.ready),
    .rsp_valid            (rsp.valid),
    .rsp_ready            (rsp.ready),
    .rsp_status           (rsp.status),
    .rsp_new_pid          (rsp.new_pid),
    .rsp_physical_address (rsp.physical_address),
    .rsp_previous_valid   (rsp.previous_valid)
);

/* tb/tb.sv */
// Self-checking testbench for base_bound_mmu_first_fit_alloc: directed and random actions
// are checked against a behavioural model of the allocator and process table.
// Depends on bbm_pkg, bbm_cmd_if, bbm_rsp_if and the block itself.
`timescale 1ns / 1ps

module tb;
    import bbm_pkg::*;

    localparam int MEM_UNITS     = 4096;
    localparam int PROCESS_SLOTS = 10;
    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_ITEMS  = 1100;
    localparam logic [ACTION_W-1:0] ACT_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PID_W-1:0]    new_pid;
        logic [PADDR_W-1:0]  physical_address;
        logic                previous_valid;
        logic [PID_W-1:0]    previous_pid;
    } mmu_response_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    bbm_cmd_if cmd ();
    bbm_rsp_if rsp ();

    base_bound_mmu_first_fit_alloc #(
        .MEM_UNITS     (MEM_UNITS),
        .PROCESS_SLOTS (PROCESS_SLOTS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    bit                unit_used [MEM_UNITS]         = '{default: 1'b0};
    bit                slot_used [PROCESS_SLOTS]     = '{default: 1'b0};
    bit [BASE_W-1:0]   slot_base [PROCESS_SLOTS]     = '{default: '0};
    bit [SIZE_W-1:0]   slot_bound [PROCESS_SLOTS]    = '{default: '0};
    bit [BASE_W-1:0]   live_base                     = '0;
    bit [SIZE_W-1:0]   live_bound                    = '0;
    bit                process_running               = 1'b0;
    bit [PID_W-1:0]    running_pid                   = '0;

    mmu_response_t pending_responses [$];
    int  error_count = 0;
    int  quiet_cycles = 0;
    bit  sender_idles = 1'b1;
    bit  receiver_idles = 1'b1;

    always #5 clk = ~clk;

    function automatic mmu_response_t predict_response(
        input logic [ACTION_W-1:0] action,
        input logic [SIZE_W-1:0]   size,
        input logic [PID_W-1:0]    pid,
        input logic [VADDR_W-1:0]  vaddr
    );
        mmu_response_t r;
        int run_len;
        int run_start;
        bit found;
        bit placed;
        r = '0;
        run_len = 0;
        run_start = 0;
        found = 1'b0;
        placed = 1'b0;
        case (action)
            ACT_CREATE:
            begin
                if (size != 0 && size <= MEM_UNITS)
                begin
                    for (int i = 0; i < MEM_UNITS && !found; i++)
                    begin
                        if (unit_used[i])
                            run_len = 0;
                        else
                        begin
                            if (run_len == 0)
                                run_start = i;
                            run_len++;
                            if (run_len == size)
                                found = 1'b1;
                        end
                    end
                end
                if (!found)
                    r.status = STAT_NO_RUN;
                else
                begin
                    for (int i = run_start; i < run_start + size; i++)
                        unit_used[i] = 1'b1;
                    r.status = STAT_NO_SLOT;
                    for (int s = 0; s < PROCESS_SLOTS && !placed; s++)
                    begin
                        if (!slot_used[s])
                        begin
                            slot_used[s] = 1'b1;
                            slot_base[s] = BASE_W'(run_start);
                            slot_bound[s] = size;
                            r.new_pid = PID_W'(s);
                            r.status = STAT_OK;
                            placed = 1'b1;
                        end
                    end
                end
            end
            ACT_SWITCH:
            begin
                if (pid >= PROCESS_SLOTS)
                    r.status = STAT_BAD_PID;
                else
                begin
                    if (process_running)
                    begin
                        slot_base[running_pid] = live_base;
                        slot_bound[running_pid] = live_bound;
                        r.previous_valid = 1'b1;
                        r.previous_pid = running_pid;
                    end
                    process_running = 1'b1;
                    running_pid = pid;
                    live_base = slot_base[pid];
                    live_bound = slot_bound[pid];
                end
            end
            ACT_TRANSLATE:
            begin
                if ({1'b0, vaddr} >= live_bound)
                    r.status = STAT_FAULT;
                else
                    r.physical_address = PADDR_W'(live_base + vaddr);
            end
            default:
                r = '0;
        endcase
        return r;
    endfunction

    task automatic report_error(input string msg);
        if (error_count < 100)
            $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string field, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_error($sformatf("%s is %0h, expected %0h", field, got, want));
    endtask

    task automatic send_command(
        input logic [ACTION_W-1:0] action,
        input logic [SIZE_W-1:0]   size,
        input logic [PID_W-1:0]    pid,
        input logic [VADDR_W-1:0]  vaddr
    );
        if (sender_idles && $urandom_range(0, 3) == 0)
        begin
            cmd.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        cmd.valid <= 1'b1;
        cmd.action <= action;
        cmd.size <= size;
        cmd.pid <= pid;
        cmd.virt_addr <= vaddr;
        do
            @(posedge clk);
        while (!cmd.ready);
        pending_responses.push_back(predict_response(action, size, pid, vaddr));
    endtask

    task automatic wait_for_responses();
        cmd.valid <= 1'b0;
        wait (pending_responses.size() == 0);
    endtask

    task automatic test_nothing_running();
        send_command(ACT_TRANSLATE, '0, '0, 12'd0);
        send_command(ACT_TRANSLATE, '1, '1, 12'hFFF);
        send_command(ACT_SWITCH, '0, 4'd15, '0);
        send_command(ACT_SWITCH, '0, 4'(PROCESS_SLOTS), '0);
        send_command(ACT_SWITCH, '0, 4'(PROCESS_SLOTS - 1), '0);
        send_command(ACT_TRANSLATE, '0, '0, 12'd0);
        send_command(ACT_UNKNOWN, '1, '1, '1);
        send_command(ACT_UNKNOWN, '0, '0, '0);
    endtask

    task automatic test_create_limits();
        send_command(ACT_CREATE, 13'd0, '0, '0);
        send_command(ACT_CREATE, 13'h1FFF, '1, '1);
        send_command(ACT_CREATE, 13'(MEM_UNITS + 1), '0, '0);
        send_command(ACT_CREATE, 13'd1, '0, '0);
        send_command(ACT_CREATE, 13'(MEM_UNITS), '0, '0);
        send_command(ACT_CREATE, 13'd7, '0, '0);
    endtask

    task automatic test_switch_and_translate();
        send_command(ACT_SWITCH, '0, 4'd0, '0);
        send_command(ACT_TRANSLATE, '0, '0, 12'd0);
        send_command(ACT_TRANSLATE, '0, '0, 12'd1);
        send_command(ACT_TRANSLATE, '0, '0, 12'hFFF);
        send_command(ACT_SWITCH, '0, 4'd1, '0);
        send_command(ACT_TRANSLATE, '0, '0, 12'd6);
        send_command(ACT_TRANSLATE, '0, '0, 12'd7);
        send_command(ACT_SWITCH, '0, 4'd10, '0);
        send_command(ACT_SWITCH, '0, 4'd0, '0);
        send_command(ACT_TRANSLATE, '0, '0, 12'd0);
    endtask

    task automatic test_random_mix();
        logic [ACTION_W-1:0] action;
        logic [SIZE_W-1:0]   size;
        logic [PID_W-1:0]    pid;
        logic [VADDR_W-1:0]  vaddr;
        int roll;
        int pick;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 2)
                wait_for_responses();
            if (n == RANDOM_ITEMS - 150)
            begin
                sender_idles = 1'b0;
                receiver_idles = 1'b0;
            end
            roll = $urandom_range(0, 99);
            pick = $urandom_range(0, 99);
            size = SIZE_W'($urandom);
            pid = PID_W'($urandom);
            vaddr = VADDR_W'($urandom);
            if (roll < 25)
            begin
                action = ACT_CREATE;
                if (pick < 80)
                    size = SIZE_W'($urandom_range(1, 8));
                else if (pick < 92)
                    size = SIZE_W'($urandom_range(9, 64));
                else if (pick < 95)
                    size = '0;
                else if (pick < 98)
                    size = SIZE_W'($urandom_range(MEM_UNITS + 1, 8191));
            end
            else if (roll < 50)
            begin
                action = ACT_SWITCH;
                if (pick < 80)
                    pid = PID_W'($urandom_range(0, PROCESS_SLOTS - 1));
                else
                    pid = PID_W'($urandom_range(PROCESS_SLOTS, 15));
            end
            else if (roll < 95)
            begin
                action = ACT_TRANSLATE;
                if (pick < 70 && live_bound != 0)
                    vaddr = VADDR_W'($urandom_range(0, live_bound - 1));
                else if (pick < 85)
                    vaddr = VADDR_W'(($urandom_range(0, 1) == 0) ? live_bound : live_bound - 1);
            end
            else
                action = ACT_UNKNOWN;
            send_command(action, size, pid, vaddr);
        end
    endtask

    task automatic test_full_memory();
        int free_units;
        free_units = 0;
        for (int s = 0; s < PROCESS_SLOTS; s++)
            if (!slot_used[s])
                send_command(ACT_CREATE, 13'd1, '0, '0);
        foreach (unit_used[i])
            if (!unit_used[i])
                free_units++;
        if (free_units > 0)
            send_command(ACT_CREATE, SIZE_W'(free_units), '0, '0);
        send_command(ACT_CREATE, 13'd1, '0, '0);
        send_command(ACT_SWITCH, '0, 4'd0, '0);
        send_command(ACT_TRANSLATE, '0, '0, 12'd0);
        send_command(ACT_SWITCH, '0, 4'(PROCESS_SLOTS - 1), '0);
        send_command(ACT_TRANSLATE, '0, '0, 12'd0);
    endtask

    initial
    begin
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (receiver_idles && $urandom_range(0, 3) == 0)
            begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            rsp.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : response_check
        mmu_response_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_responses.size() == 0)
                report_error("response transaction with no command outstanding");
            else
            begin
                want = pending_responses.pop_front();
                check_field("status", 16'(rsp.status), 16'(want.status));
                check_field("new_pid", 16'(rsp.new_pid), 16'(want.new_pid));
                check_field("physical_address", 16'(rsp.physical_address),
                            16'(want.physical_address));
                check_field("previous_valid", 16'(rsp.previous_valid),
                            16'(want.previous_valid));
                check_field("previous_pid", 16'(rsp.previous_pid),
                            16'(want.previous_pid));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        cmd.valid <= 1'b0;
        cmd.action <= ACT_CREATE;
        cmd.size <= '0;
        cmd.pid <= '0;
        cmd.virt_addr <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_nothing_running();
        test_create_limits();
        test_switch_and_translate();
        test_random_mix();
        test_full_memory();
        cmd.valid <= 1'b0;
        wait (pending_responses.size() == 0);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
